[rtl/cts_pkg.sv]
// Shared widths, datapath types and elaboration-time CORDIC constants.
`default_nettype none
package cts_pkg;

  localparam int unsigned IN_W      = 24;  // coordinate width
  localparam int unsigned FRAC      = 24;  // fraction bits inside the passes
  localparam int unsigned CW        = 51;  // signed CORDIC x/y width
  localparam int unsigned MW        = CW - 1;  // unsigned magnitude width
  localparam int unsigned AW        = 43;  // signed angle width, 2^-32 degree
  localparam int unsigned RW        = AW - FRAC;  // rounded angle width
  localparam int unsigned GW        = 30;  // inverse gain, unsigned Q30
  localparam int unsigned MAX_STEPS = 32;
  localparam int          ANG_LIMIT = 46080;

  // 180 degrees in units of 2^-32 degree
  localparam logic signed [AW-1:0] HALF_TURN = 43'sd773094113280;

  typedef struct packed {
    logic signed [CW-1:0] u;
    logic signed [CW-1:0] v;
    logic signed [AW-1:0] ang;
  } cts_rot_t;

  typedef struct packed {
    logic origin;
    logic y_zero;
    logic x_neg;
    logic xy_zero;
  } cts_flags_t;

  // sideband through the first pass
  typedef struct packed {
    logic signed [IN_W-1:0] pos_z;
    cts_flags_t             flags;
  } cts_sb1_t;

  // sideband through the second pass
  typedef struct packed {
    logic signed [AW-1:0] phi;
    logic [IN_W-1:0]      abs_z;
    logic                 z_pos;
    cts_flags_t           flags;
  } cts_sb2_t;

  // unsigned quotient by restoring long division, one bit per pass
  function automatic logic [63:0] cts_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    int unsigned b;
    q = 64'd0;
    r = 65'd0;
    for (b = 64; b > 0; b--) begin
      r = {r[63:0], num[b-1]};
      if (r >= {1'b0, den}) begin
        r        = r - {1'b0, den};
        q[b-1]   = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(1/n) in Q60 radians; n = 2^lg for lg > 0, else 239 or 5
  function automatic logic [63:0] cts_atan_inv(input int unsigned lg, input bit big);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned k;
    bit sub;
    bit done;
    if (lg != 0) p = 64'd1 << (60 - lg);
    else if (big) p = (64'd1 << 60) / 64'd239;
    else p = (64'd1 << 60) / 64'd5;
    sum  = p;
    sub  = 1'b1;
    done = 1'b0;
    for (k = 1; k < 64; k++) begin
      if (!done) begin
        if (lg != 0) p = p >> (2 * lg);
        else if (big) p = p / 64'd57121;
        else p = p / 64'd25;
        if (p == 64'd0) begin
          done = 1'b1;
        end else begin
          t   = cts_udiv(p, 64'(2 * k + 1));
          sum = sub ? sum - t : sum + t;
          sub = !sub;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] cts_quarter_pi();
    return 64'd4 * cts_atan_inv(0, 1'b0) - cts_atan_inv(0, 1'b1);
  endfunction

  // (180/pi) * 2^24 by restoring long division
  function automatic logic [63:0] cts_deg_scale();
    logic [63:0] rem;
    logic [63:0] ds;
    logic [63:0] qp;
    int unsigned b;
    qp  = cts_quarter_pi();
    rem = 64'd45 << 54;
    ds  = 64'd0;
    for (b = 0; b < 30; b++) begin
      rem = rem << 1;
      ds  = ds << 1;
      if (rem >= qp) begin
        rem = rem - qp;
        ds  = ds | 64'd1;
      end
    end
    return ds;
  endfunction

  // arctan(2^-i) in units of 2^-32 degree
  function automatic logic [63:0] cts_atan(input int unsigned i);
    logic [63:0] rad;
    logic [63:0] ds;
    rad = (i == 0) ? cts_quarter_pi() : cts_atan_inv(i, 1'b0);
    ds  = cts_deg_scale();
    return (((rad >> 32) * ds) >> 20) + (((rad & 64'hFFFF_FFFF) * ds) >> 52);
  endfunction

  function automatic logic [63:0] cts_isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    int unsigned j;
    v   = val;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // inverse CORDIC gain for a given number of iterations, Q30
  function automatic logic [63:0] cts_inv_gain(input int unsigned steps);
    logic [63:0] gain2;
    int unsigned i;
    gain2 = 64'd1 << 60;
    for (i = 0; i < MAX_STEPS; i++) begin
      if (i < steps) gain2 = gain2 + (gain2 >> (2 * i));
    end
    return cts_udiv(64'd1 << 60, cts_isqrt(gain2));
  endfunction

endpackage
`default_nettype wire

[rtl/cts_cell.sv]
// One CORDIC vectoring iteration as a registered pipeline cell.
`default_nettype none
module cts_cell import cts_pkg::*; #(
  parameter int unsigned STEP = 0,
  parameter int unsigned SB_W = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cts_rot_t        rot_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output cts_rot_t        rot_o,
  output logic [SB_W-1:0] sb_o
);

  localparam logic signed [AW-1:0] ATAN = AW'(cts_atan(STEP));

  logic                 valid_q;
  cts_rot_t             rot_d;
  cts_rot_t             rot_q;
  logic [SB_W-1:0]      sb_q;
  logic signed [CW-1:0] u_sh;
  logic signed [CW-1:0] v_sh;

  // rotate toward v = 0, direction chosen by the sign of v
  always_comb begin
    u_sh = rot_i.u >>> STEP;
    v_sh = rot_i.v >>> STEP;
    if (!rot_i.v[CW-1]) begin
      rot_d.u   = rot_i.u + v_sh;
      rot_d.v   = rot_i.v - u_sh;
      rot_d.ang = rot_i.ang + ATAN;
    end else begin
      rot_d.u   = rot_i.u - v_sh;
      rot_d.v   = rot_i.v + u_sh;
      rot_d.ang = rot_i.ang - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
      sb_q  <= sb_i;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign sb_o    = sb_q;

endmodule
`default_nettype wire

[rtl/cts_gain.sv]
// Two-stage multiply by the inverse CORDIC gain, result truncated.
`default_nettype none
module cts_gain import cts_pkg::*; #(
  parameter int unsigned STEPS = 24,
  parameter int unsigned SB_W  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [MW-1:0]   mag_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [MW-1:0]   mag_o,
  output logic [SB_W-1:0] sb_o
);

  localparam logic [GW-1:0] GAIN = GW'(cts_inv_gain(STEPS));
  localparam int unsigned LO_W = MW / 2;
  localparam int unsigned HI_W = MW - LO_W;

  logic                   va_q;
  logic [LO_W+GW-1:0]     lo_q;
  logic [HI_W-1:0]        hi_q;
  logic [SB_W-1:0]        sba_q;
  logic                   vb_q;
  logic [MW-1:0]          mag_q;
  logic [SB_W-1:0]        sbb_q;
  logic [LO_W+GW-1:0]     lo_prod;
  logic [HI_W+GW-1:0]     hi_prod;
  logic [MW+GW-1:0]       full;

  // low half first, high half and the sum one stage later
  assign lo_prod = mag_i[LO_W-1:0] * GAIN;
  assign hi_prod = hi_q * GAIN;
  assign full    = {hi_prod, LO_W'(0)} + (MW + GW)'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= lo_prod;
      hi_q  <= mag_i[MW-1:LO_W];
      sba_q <= sb_i;
      mag_q <= full[MW+GW-1:GW];
      sbb_q <= sba_q;
    end
  end

  assign valid_o = vb_q;
  assign mag_o   = mag_q;
  assign sb_o    = sbb_q;

endmodule
`default_nettype wire

[rtl/cartesian_to_spherical.sv]
// Top level: cartesian point to radius, polar angle and azimuth.
// Request to out_valid_o: stage 0, a chain of CORDIC cells, u_gain1, the stage
//   between passes, a second chain of CORDIC cells, u_gain2, finish, output.
// Throughput: one request per cycle; all stages advance together and stall only
//   when the last stage and the output register both hold unread results.
// Reset: rst_ni clears every stage valid bit and the output valid; data holds.
`default_nettype none
module cartesian_to_spherical import cts_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] pos_x_i,
  input  logic signed [IN_W-1:0] pos_y_i,
  input  logic signed [IN_W-1:0] pos_z_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [23:0]            radius_o,
  output logic [15:0]            polar_angle_o,
  output logic signed [16:0]     azimuth_o,
  output logic                   at_origin_o
);

  localparam int unsigned NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int unsigned SB1_W = $bits(cts_sb1_t);
  localparam int unsigned SB2_W = $bits(cts_sb2_t);

  // ---------------------------------------------------------------------------
  // Flow control: the output register takes the last stage whenever it is free
  // or being read. The pipeline also advances when the last stage is empty, so
  // a request is still taken while a finished result waits at the output.
  // ---------------------------------------------------------------------------
  logic load_out;
  logic pipe_en;
  logic fin_valid_q;
  logic out_valid_q;

  assign load_out   = !out_valid_q || out_ready_i;
  assign pipe_en    = load_out || !fin_valid_q;
  assign in_ready_o = pipe_en;

  // ---------------------------------------------------------------------------
  // Stage 0: fold the left half-plane onto the right one and scale to Q24.
  // ---------------------------------------------------------------------------
  logic                 s0_valid_q;
  cts_rot_t             s0_rot_d;
  cts_rot_t             s0_rot_q;
  cts_sb1_t             s0_sb_d;
  cts_sb1_t             s0_sb_q;
  logic signed [CW-1:0] x_sc;
  logic signed [CW-1:0] y_sc;

  always_comb begin
    x_sc = CW'(pos_x_i) <<< FRAC;
    y_sc = CW'(pos_y_i) <<< FRAC;
    if (pos_x_i[IN_W-1]) begin
      s0_rot_d.u   = -x_sc;
      s0_rot_d.v   = -y_sc;
      s0_rot_d.ang = pos_y_i[IN_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      s0_rot_d.u   = x_sc;
      s0_rot_d.v   = y_sc;
      s0_rot_d.ang = '0;
    end
    s0_sb_d.pos_z         = pos_z_i;
    s0_sb_d.flags.origin  = (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0);
    s0_sb_d.flags.y_zero  = (pos_y_i == '0);
    s0_sb_d.flags.x_neg   = pos_x_i[IN_W-1];
    s0_sb_d.flags.xy_zero = (pos_x_i == '0) && (pos_y_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_rot_q <= s0_rot_d;
      s0_sb_q  <= s0_sb_d;
    end
  end

  // ---------------------------------------------------------------------------
  // First pass: (x, y) vectoring gives azimuth and gained planar distance.
  // ---------------------------------------------------------------------------
  logic             p1_valid [NSTEP+1];
  cts_rot_t         p1_rot   [NSTEP+1];
  logic [SB1_W-1:0] p1_sb    [NSTEP+1];

  assign p1_valid[0] = s0_valid_q;
  assign p1_rot[0]   = s0_rot_q;
  assign p1_sb[0]    = s0_sb_q;

  for (genvar k = 0; k < NSTEP; k++) begin : g_pass1
    cts_cell #(
      .STEP (k),
      .SB_W (SB1_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (p1_valid[k]),
      .rot_i   (p1_rot[k]),
      .sb_i    (p1_sb[k]),
      .valid_o (p1_valid[k+1]),
      .rot_o   (p1_rot[k+1]),
      .sb_o    (p1_sb[k+1])
    );
  end

  // remove the gain from the planar distance, carry azimuth alongside
  logic                g1_valid;
  logic [MW-1:0]       g1_mag;
  logic [AW+SB1_W-1:0] g1_sb;

  cts_gain #(
    .STEPS (NSTEP),
    .SB_W  (AW + SB1_W)
  ) u_gain1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p1_valid[NSTEP]),
    .mag_i   (p1_rot[NSTEP].u[MW-1:0]),
    .sb_i    ({p1_rot[NSTEP].ang, p1_sb[NSTEP]}),
    .valid_o (g1_valid),
    .mag_o   (g1_mag),
    .sb_o    (g1_sb)
  );

  // ---------------------------------------------------------------------------
  // Stage between passes: set up (z, planar), folding negative z over.
  // ---------------------------------------------------------------------------
  cts_sb1_t             g1_sb1;
  logic signed [CW-1:0] planar;
  logic signed [CW-1:0] z_sc;
  logic                 z_neg;
  logic                 s2_valid_q;
  cts_rot_t             s2_rot_d;
  cts_rot_t             s2_rot_q;
  cts_sb2_t             s2_sb_d;
  cts_sb2_t             s2_sb_q;

  always_comb begin
    g1_sb1 = cts_sb1_t'(g1_sb[SB1_W-1:0]);
    planar = $signed({1'b0, g1_mag});
    z_sc   = CW'(g1_sb1.pos_z) <<< FRAC;
    z_neg  = g1_sb1.pos_z[IN_W-1];
    if (z_neg) begin
      s2_rot_d.u    = -z_sc;
      s2_rot_d.v    = -planar;
      s2_rot_d.ang  = HALF_TURN;
      s2_sb_d.abs_z = IN_W'(-g1_sb1.pos_z);
    end else begin
      s2_rot_d.u    = z_sc;
      s2_rot_d.v    = planar;
      s2_rot_d.ang  = '0;
      s2_sb_d.abs_z = IN_W'(g1_sb1.pos_z);
    end
    s2_sb_d.phi   = $signed(g1_sb[SB1_W +: AW]);
    s2_sb_d.z_pos = !z_neg && (g1_sb1.pos_z != '0);
    s2_sb_d.flags = g1_sb1.flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= g1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_rot_q <= s2_rot_d;
      s2_sb_q  <= s2_sb_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Second pass: (z, planar) vectoring gives polar angle and gained radius.
  // ---------------------------------------------------------------------------
  logic             p2_valid [NSTEP+1];
  cts_rot_t         p2_rot   [NSTEP+1];
  logic [SB2_W-1:0] p2_sb    [NSTEP+1];

  assign p2_valid[0] = s2_valid_q;
  assign p2_rot[0]   = s2_rot_q;
  assign p2_sb[0]    = s2_sb_q;

  for (genvar k = 0; k < NSTEP; k++) begin : g_pass2
    cts_cell #(
      .STEP (k),
      .SB_W (SB2_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (p2_valid[k]),
      .rot_i   (p2_rot[k]),
      .sb_i    (p2_sb[k]),
      .valid_o (p2_valid[k+1]),
      .rot_o   (p2_rot[k+1]),
      .sb_o    (p2_sb[k+1])
    );
  end

  logic                g2_valid;
  logic [MW-1:0]       g2_mag;
  logic [AW+SB2_W-1:0] g2_sb;

  cts_gain #(
    .STEPS (NSTEP),
    .SB_W  (AW + SB2_W)
  ) u_gain2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (p2_valid[NSTEP]),
    .mag_i   (p2_rot[NSTEP].u[MW-1:0]),
    .sb_i    ({p2_rot[NSTEP].ang, p2_sb[NSTEP]}),
    .valid_o (g2_valid),
    .mag_o   (g2_mag),
    .sb_o    (g2_sb)
  );

  // ---------------------------------------------------------------------------
  // Finish stage: round to output units, clamp angles, saturate the radius,
  // apply the axis cases.
  localparam logic signed [RW-1:0] ANG_MAX = RW'(ANG_LIMIT);

  cts_sb2_t             g2_sb2;
  logic signed [AW-1:0] theta_add;
  logic signed [AW-1:0] phi_add;
  logic signed [RW-1:0] theta_r;
  logic signed [RW-1:0] phi_r;
  logic [MW:0]          rad_sum;
  logic [MW-FRAC:0]     rad_full;
  logic [23:0]          fin_radius_d;
  logic [15:0]          fin_polar_d;
  logic signed [16:0]   fin_azim_d;
  logic [23:0]          fin_radius_q;
  logic [15:0]          fin_polar_q;
  logic signed [16:0]   fin_azim_q;
  logic                 fin_origin_q;

  always_comb begin
    g2_sb2    = cts_sb2_t'(g2_sb[SB2_W-1:0]);
    theta_add = $signed(g2_sb[SB2_W +: AW]) + AW'(1 << (FRAC - 1));
    phi_add   = g2_sb2.phi + AW'(1 << (FRAC - 1));
    theta_r   = $signed(theta_add[AW-1:FRAC]);
    phi_r     = $signed(phi_add[AW-1:FRAC]);
    rad_sum   = {1'b0, g2_mag} + (MW + 1)'(1 << (FRAC - 1));
    rad_full  = rad_sum[MW:FRAC];

    // clamp the CORDIC residue back into range
    if (theta_r < 0) fin_polar_d = '0;
    else if (theta_r > ANG_MAX) fin_polar_d = 16'(ANG_LIMIT);
    else fin_polar_d = theta_r[15:0];

    if (phi_r < -ANG_MAX) fin_azim_d = -17'sd46080;
    else if (phi_r > ANG_MAX) fin_azim_d = 17'sd46080;
    else fin_azim_d = phi_r[16:0];

    fin_radius_d = rad_full[23:0];

    // on the x axis the azimuth is exact
    if (g2_sb2.flags.y_zero) begin
      fin_azim_d = g2_sb2.flags.x_neg ? 17'sd46080 : 17'sd0;
    end
    // on the z axis: radius is |z|, pole angle from the sign of z
    if (g2_sb2.flags.xy_zero) begin
      fin_polar_d  = g2_sb2.z_pos ? 16'd0 : 16'(ANG_LIMIT);
      fin_radius_d = g2_sb2.abs_z;
    end
    // saturate only when the rounded radius left 24 bits
    if (!g2_sb2.flags.xy_zero && (rad_full > (MW - FRAC + 1)'(24'hFF_FFFF))) begin
      fin_radius_d = 24'hFF_FFFF;
    end
    // origin: everything zero
    if (g2_sb2.flags.origin) begin
      fin_radius_d = '0;
      fin_polar_d  = '0;
      fin_azim_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (pipe_en) begin
      fin_valid_q <= g2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      fin_radius_q <= fin_radius_d;
      fin_polar_q  <= fin_polar_d;
      fin_azim_q   <= fin_azim_d;
      fin_origin_q <= g2_sb2.flags.origin;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold until the consumer takes the result.
  // ---------------------------------------------------------------------------
  logic [23:0]        out_radius_q;
  logic [15:0]        out_polar_q;
  logic signed [16:0] out_azim_q;
  logic               out_origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && fin_valid_q) begin
      out_radius_q <= fin_radius_q;
      out_polar_q  <= fin_polar_q;
      out_azim_q   <= fin_azim_q;
      out_origin_q <= fin_origin_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign radius_o      = out_radius_q;
  assign polar_angle_o = out_polar_q;
  assign azimuth_o     = out_azim_q;
  assign at_origin_o   = out_origin_q;

`ifndef SYNTH
  // a result at the origin carries no radius and no angles
  a_origin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_origin_o |-> radius_o == '0 && polar_angle_o == '0 &&
    azimuth_o == '0)
    else $error("origin result with nonzero fields");

  // angles stay inside their ranges after clamping
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> polar_angle_o <= 16'd46080 && azimuth_o <= 17'sd46080 &&
    azimuth_o >= -17'sd46080)
    else $error("angle out of range");

  // a finished result blocked by a stalled output must not be overwritten
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && out_valid_q && !out_ready_i |=> fin_valid_q && $stable(fin_radius_q))
    else $error("last stage advanced while output stalled");
`endif

endmodule
`default_nettype wire
